// ----- hdl/bilinear_texture_sampler_defines.svh -----
// Assertion macros used by the sampler RTL.
`ifndef BILINEAR_TEXTURE_SAMPLER_DEFINES_SVH
`define BILINEAR_TEXTURE_SAMPLER_DEFINES_SVH

// Checks that a condition implies a consequence on the same edge.
`define BTS_ASSERT_IMPL(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// Checks that a condition implies a consequence on the next edge.
`define BTS_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/bts_pkg.sv -----
package bts_pkg;

   localparam int unsigned FracBits = 16;
   localparam int unsigned CoordBits = 32;
   localparam int unsigned SizeBits = 9;
   localparam int unsigned ColBits = 8;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_SAMPLE = 1'b1
   } command_type;

   typedef enum logic {
      CSR_TEX_WIDTH = 1'b0,
      CSR_TEX_HEIGHT = 1'b1
   } csr_index_type;

endpackage

// ----- hdl/bts_req_if.sv -----
interface bts_req_if #(
   parameter int unsigned CHANNEL_BITS = 16
);
   logic                    valid;
   logic                    ready;
   logic                    command;
   logic [7:0]              texel_col;
   logic [7:0]              texel_row;
   logic [CHANNEL_BITS-1:0] texel_red;
   logic [CHANNEL_BITS-1:0] texel_green;
   logic [CHANNEL_BITS-1:0] texel_blue;
   logic signed [31:0]      coord_u;
   logic signed [31:0]      coord_v;

   modport source (output valid, command, texel_col, texel_row, texel_red, texel_green,
                   texel_blue, coord_u, coord_v, input ready);
   modport sink (input valid, command, texel_col, texel_row, texel_red, texel_green,
                 texel_blue, coord_u, coord_v, output ready);
endinterface

// ----- hdl/bts_rsp_if.sv -----
interface bts_rsp_if #(
   parameter int unsigned CHANNEL_BITS = 16
);
   logic                    valid;
   logic                    ready;
   logic [CHANNEL_BITS-1:0] out_red;
   logic [CHANNEL_BITS-1:0] out_green;
   logic [CHANNEL_BITS-1:0] out_blue;

   modport source (output valid, out_red, out_green, out_blue, input ready);
   modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

// ----- hdl/bts_ram.sv -----
module bts_ram #(
   parameter int unsigned WIDTH = 48,
   parameter int unsigned DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- hdl/bts_lerp.sv -----
// One channel of a two-stage bilinear blend: horizontal lerps, then vertical.
module bts_lerp #(
   parameter int unsigned CHANNEL_BITS = 16
) (
   input  logic                    clock,
   input  logic                    en_h,
   input  logic                    en_v,
   input  logic [CHANNEL_BITS-1:0] q11,
   input  logic [CHANNEL_BITS-1:0] q21,
   input  logic [CHANNEL_BITS-1:0] q12,
   input  logic [CHANNEL_BITS-1:0] q22,
   input  logic [15:0]             fx,
   input  logic [15:0]             fy,
   output logic [CHANNEL_BITS-1:0] result
);
   localparam int unsigned RW = CHANNEL_BITS + 17;
   localparam int unsigned AW = RW + 17;

   logic [16:0]   wx1, wy1;
   logic [RW-1:0] r1_in, r2_in, r1_ff, r2_ff;
   logic [16:0]   fy_ff;
   logic [AW-1:0] acc_in;
   logic [CHANNEL_BITS-1:0] result_ff;

   always_comb begin
      wx1 = 17'h10000 - {1'b0, fx};
      r1_in = RW'(q11) * RW'(wx1) + RW'(q21) * RW'(fx);
      r2_in = RW'(q12) * RW'(wx1) + RW'(q22) * RW'(fx);
      wy1 = 17'h10000 - fy_ff;
      acc_in = AW'(r1_ff) * AW'(wy1) + AW'(r2_ff) * AW'(fy_ff);
   end

   always_ff @(posedge clock) begin
      if (en_h) begin
         r1_ff <= r1_in;
         r2_ff <= r2_in;
         fy_ff <= {1'b0, fy};
      end
      if (en_v) begin
         result_ff <= acc_in[32 +: CHANNEL_BITS];
      end
   end

   assign result = (CHANNEL_BITS > 16) ? (result_ff & CHANNEL_BITS'(16'hFFFF)) : result_ff;
endmodule

// ----- hdl/bilinear_texture_sampler.sv -----
// Bilinear texture sampler.
// Requests arrive on req_ (valid/ready). A write transaction (command 0) stores
// one RGB texel at (texel_col, texel_row) and returns nothing. A sample
// transaction (command 1) wraps coord_u/coord_v to fractions, flips v, scales
// by the csr_ width and height and blends the four neighboring texels; one
// response transaction per sample leaves on rsp_.
// The texel store is split into four banks by column and row parity, so all
// four neighbors are read in the same cycle. The pipeline is five stages:
// scale, bank read, neighbor select, horizontal blend, vertical blend.
// rsp_valid is the valid bit of the vertical blend stage. One transaction is
// taken per cycle while the receiver does not stall. When the receiver stalls
// with the last stage full, the whole pipeline holds and req_ready drops;
// nothing is lost or repeated. Reset clears the stage valid bits and sets
// width and height to 256. Texels are undefined until written; there is no
// clearing pass. Writes reach the banks at the accepting edge, so a sample
// that follows a write sees it. The user must write configuration through
// csr_ only while the block is idle; the block itself does not enforce this.
module bilinear_texture_sampler
   import bts_pkg::*;
#(
   parameter int unsigned MAX_WIDTH = 256,
   parameter int unsigned MAX_HEIGHT = 256,
   parameter int unsigned CHANNEL_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   bts_req_if.sink     req,
   bts_rsp_if.source   rsp,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [8:0]  csr_wr_data
);
`include "bilinear_texture_sampler_defines.svh"

   localparam int unsigned XB = $clog2(MAX_WIDTH);
   localparam int unsigned YB = $clog2(MAX_HEIGHT);
   localparam int unsigned BD = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2) > 0 ?
                                (MAX_WIDTH / 2) * (MAX_HEIGHT / 2) : 1;
   localparam int unsigned BA = (BD > 1) ? $clog2(BD) : 1;
   localparam int unsigned TW = 3 * CHANNEL_BITS;

   logic [8:0] tex_width_ff, tex_height_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         tex_width_ff <= 9'd256;
         tex_height_ff <= 9'd256;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TEX_WIDTH: tex_width_ff <= csr_wr_data;
            CSR_TEX_HEIGHT: tex_height_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Pipeline control: every stage advances when the last one can move.
   logic [4:0] vld_ff;
   logic adv;
   assign adv = !vld_ff[4] || rsp.ready;
   assign req.ready = adv;

   logic acc_req;
   assign acc_req = req.valid && adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[3:0], acc_req && (req.command == CMD_SAMPLE)};
      end
   end

   // Stage 1: scale coordinates.
   logic [16:0] fu, fv;
   logic [25:0] x_in, y_in;
   logic [25:0] x_ff, y_ff;
   logic [8:0]  w_ff, h_ff;
   always_comb begin
      fu = {1'b0, req.coord_u[15:0]};
      fv = 17'h10000 - {1'b0, req.coord_v[15:0]};
      x_in = 26'(fu) * 26'(tex_width_ff);
      y_in = 26'(fv) * 26'(tex_height_ff);
   end

   logic wr_ok;
   assign wr_ok = acc_req && (req.command == CMD_WRITE) &&
                  (32'(req.texel_col) < MAX_WIDTH) && (32'(req.texel_row) < MAX_HEIGHT);

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff <= x_in;
         y_ff <= y_in;
         w_ff <= tex_width_ff;
         h_ff <= tex_height_ff;
      end
   end

   // Stage 2: bank addressing and read.
   logic [9:0] x1, x2, y1, y2;
   assign x1 = x_ff[25:16];
   assign y1 = y_ff[25:16];
   assign x2 = x1 + 10'd1;
   assign y2 = y1 + 10'd1;

   // For bank (px, py) the column is whichever neighbor column has parity px.
   logic [9:0] bcol [2], brow [2];
   assign bcol[0] = x1[0] ? x2 : x1;
   assign bcol[1] = x1[0] ? x1 : x2;
   assign brow[0] = y1[0] ? y2 : y1;
   assign brow[1] = y1[0] ? y1 : y2;

   logic [TW-1:0] bank_q [4];
   genvar g;
   generate
      for (g = 0; g < 4; g++) begin : g_bank
         logic [BA-1:0] ra, wa;
         logic [31:0]   rc, rr, wc, wr;
         assign rc = 32'(bcol[g % 2]) >> 1;
         assign rr = 32'(brow[g / 2]) >> 1;
         assign ra = BA'(rr * (MAX_WIDTH / 2) + rc);
         assign wc = 32'(req.texel_col) >> 1;
         assign wr = 32'(req.texel_row) >> 1;
         assign wa = BA'(wr * (MAX_WIDTH / 2) + wc);
         bts_ram #(.WIDTH(TW), .DEPTH(BD)) u_ram (
            .clock   (clock),
            .wr_en   (wr_ok && (req.texel_col[0] == 1'(g % 2)) &&
                      (req.texel_row[0] == 1'(g / 2))),
            .wr_addr (wa),
            .wr_data ({req.texel_red, req.texel_green, req.texel_blue}),
            .rd_en   (adv),
            .rd_addr (ra),
            .rd_data (bank_q[g])
         );
      end
   endgenerate

   logic [3:0]  in_ff;
   logic        xp_ff, yp_ff;
   logic [15:0] fx2_ff, fy2_ff;
   logic in11, in21, in12, in22, cx1, cx2, cy1, cy2;
   assign cx1 = ({1'b0, x1} < {1'b0, w_ff}) && (32'(x1) < MAX_WIDTH);
   assign cx2 = ({1'b0, x2} < {1'b0, w_ff}) && (32'(x2) < MAX_WIDTH);
   assign cy1 = ({1'b0, y1} < {1'b0, h_ff}) && (32'(y1) < MAX_HEIGHT);
   assign cy2 = ({1'b0, y2} < {1'b0, h_ff}) && (32'(y2) < MAX_HEIGHT);
   assign in11 = cx1 && cy1;
   assign in21 = cx2 && cy1;
   assign in12 = cx1 && cy2;
   assign in22 = cx2 && cy2;

   always_ff @(posedge clock) begin
      if (adv) begin
         in_ff <= {in22, in12, in21, in11};
         xp_ff <= x1[0];
         yp_ff <= y1[0];
         fx2_ff <= x_ff[15:0];
         fy2_ff <= y_ff[15:0];
      end
   end

   // Stage 3: route banks to neighbors and mask black ones.
   logic [TW-1:0] q_in [4];
   logic [TW-1:0] q_ff [4];
   logic [15:0]   fx3_ff, fy3_ff;
   always_comb begin
      q_in[0] = in_ff[0] ? bank_q[{yp_ff, xp_ff}] : '0;
      q_in[1] = in_ff[1] ? bank_q[{yp_ff, !xp_ff}] : '0;
      q_in[2] = in_ff[2] ? bank_q[{!yp_ff, xp_ff}] : '0;
      q_in[3] = in_ff[3] ? bank_q[{!yp_ff, !xp_ff}] : '0;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         q_ff <= q_in;
         fx3_ff <= fx2_ff;
         fy3_ff <= fy2_ff;
      end
   end

   // Stages 4 and 5: blend per channel.
   logic [CHANNEL_BITS-1:0] res [3];
   generate
      for (g = 0; g < 3; g++) begin : g_chan
         localparam int unsigned LO = (2 - g) * CHANNEL_BITS;
         bts_lerp #(.CHANNEL_BITS(CHANNEL_BITS)) u_lerp (
            .clock  (clock),
            .en_h   (adv),
            .en_v   (adv),
            .q11    (q_ff[0][LO +: CHANNEL_BITS]),
            .q21    (q_ff[1][LO +: CHANNEL_BITS]),
            .q12    (q_ff[2][LO +: CHANNEL_BITS]),
            .q22    (q_ff[3][LO +: CHANNEL_BITS]),
            .fx     (fx3_ff),
            .fy     (fy3_ff),
            .result (res[g])
         );
      end
   endgenerate

   assign rsp.valid = vld_ff[4];
   assign rsp.out_red = res[0];
   assign rsp.out_green = res[1];
   assign rsp.out_blue = res[2];

   `BTS_ASSERT_NEXT(a_stall_hold, clock, reset, rsp.valid && !rsp.ready,
      rsp.valid && $stable(rsp.out_red), "stalled response changed")
   `BTS_ASSERT_IMPL(a_ready, clock, reset, !rsp.valid, req.ready,
      "ready low with empty output stage")
   `BTS_ASSERT_NEXT(a_write_silent, clock, reset,
      req.valid && req.ready && req.command == CMD_WRITE, !vld_ff[0],
      "write produced a pipeline entry")
endmodule
